// ===== src/twda_pkg.sv =====
package twda_pkg;

	// field widths of the converter word and of the result
	localparam int RAW_W  = 16;
	localparam int TEMP_W = 14;
	localparam int AVG_W  = 16;

	// default window depth
	localparam int WINDOW_DEF = 16;

	// bit position of the fault flag and the temperature field in the raw word
	localparam int FAULT_POS = 0;
	localparam int TEMP_LSB  = 2;

	// fixed-point scale: average is four times the sum over the count
	localparam int SCALE_SHIFT = 2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DROP,
		ST_UPDATE,
		ST_START,
		ST_WAIT,
		ST_LOAD
	} twda_state_t;

endpackage

// ===== src/twda_in_if.sv =====
interface twda_in_if
	import twda_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_word;

	modport source (output valid, output raw_word, input ready);
	modport sink   (input valid, input raw_word, output ready);
endinterface

// ===== src/twda_out_if.sv =====
interface twda_out_if
	import twda_pkg::*;
#(
	parameter int CNT_W = 5
) ();
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temp_quarter;
	logic                     fault;
	logic [CNT_W-1:0]         window_count;
	logic                     average_valid;
	logic signed [AVG_W-1:0]  average_sixteenth;

	modport source (output valid, output temp_quarter, output fault, output window_count,
		output average_valid, output average_sixteenth, input ready);
	modport sink   (input valid, input temp_quarter, input fault, input window_count,
		input average_valid, input average_sixteenth, output ready);
endinterface

// ===== src/twda_ram.sv =====
module twda_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/twda_div.sv =====
module twda_div #(
	parameter int DVD_W = 20,
	parameter int DVS_W = 5,
	localparam int STEP_W = $clog2(DVD_W + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              fits;

	// one restoring step: shift in the next dividend bit, try the subtract
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// step counter and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= STEP_W'(DVD_W);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (step_q != '0) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign busy     = (step_q != '0);
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/thermocouple_word_decode_average_unit.sv =====
// path: an accepted beat goes through update, start, divider wait and load to the result beat;
//   a full window first drops its oldest reading; the divider is skipped when no reading is left
// throughput: one beat at a time; the bit-serial divider (one quotient bit a cycle) sets the pace
// a finished result waits in the output register while the next beat is taken
// reset: count, sum, ring position and handshake state clear at once; the window store
//   is not cleared, as no entry is read before it is written
module thermocouple_word_decode_average_unit
	import twda_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF,
	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
	localparam int CNT_W = $clog2(WINDOW + 1),
	localparam int SUM_W = TEMP_W + $clog2(WINDOW),
	localparam int DVD_W = SUM_W + SCALE_SHIFT
) (
	input  logic              clk,
	input  logic              arst_n,
	twda_in_if.sink           sensor,
	twda_out_if.source        result
);

	localparam logic [IDX_W:0] WIN_EXT  = (IDX_W + 1)'(WINDOW);
	localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);
	localparam logic [CNT_W-1:0] WIN_DROP = CNT_W'(WINDOW - 1);

	twda_state_t state_q, state_d;

	logic [RAW_W-1:0]         word_q;
	logic [IDX_W-1:0]         oldest_q;
	logic [CNT_W-1:0]         held_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     neg_q;

	logic                     word_fault;
	logic signed [TEMP_W-1:0] word_temp;
	logic [IDX_W:0]           oldest_inc;
	logic [IDX_W-1:0]         oldest_next;
	logic [IDX_W:0]           slot_ext;
	logic [IDX_W-1:0]         slot;

	logic                     ram_we;
	logic signed [TEMP_W-1:0] ram_rdata;
	logic                     div_start;
	logic                     div_busy;
	logic                     div_done;
	logic [SUM_W-1:0]         sum_mag;
	logic [DVD_W-1:0]         div_quo;
	logic [DVD_W-1:0]         avg_signed;
	logic                     load_out;

	logic                     out_valid_q;
	logic signed [TEMP_W-1:0] out_temp_q;
	logic                     out_fault_q;
	logic [CNT_W-1:0]         out_count_q;
	logic                     out_avg_valid_q;
	logic signed [AVG_W-1:0]  out_avg_q;

	// decode of the held word
	always_comb begin
		word_fault = word_q[FAULT_POS];
		word_temp  = word_fault ? '0 : $signed(word_q[TEMP_LSB +: TEMP_W]);
	end

	// ring arithmetic: next oldest position and the slot for the new reading
	always_comb begin
		oldest_inc  = {1'b0, oldest_q} + 1'b1;
		oldest_next = (oldest_inc >= WIN_EXT) ? '0 : oldest_inc[IDX_W-1:0];
		slot_ext    = {1'b0, oldest_q} + (IDX_W + 1)'(held_q);
		slot        = (slot_ext >= WIN_EXT) ? IDX_W'(slot_ext - WIN_EXT) : slot_ext[IDX_W-1:0];
	end

	// magnitude of the scaled sum for the divider, sign applied after
	always_comb begin
		sum_mag    = (sum_q < 0) ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		avg_signed = neg_q ? (~div_quo + 1'b1) : div_quo;
	end

	twda_ram #(
		.WIDTH (TEMP_W),
		.DEPTH (WINDOW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot),
		.wdata (word_temp),
		.raddr (oldest_q),
		.rdata (ram_rdata)
	);

	twda_div #(
		.DVD_W (DVD_W),
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_mag, SCALE_SHIFT'(0)}),
		.divisor  (held_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sensor.valid) begin
					state_d = (held_q == WIN_CNT) ? ST_READ : ST_UPDATE;
				end
			end
			ST_READ:   state_d = ST_DROP;
			ST_DROP:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_START;
			ST_START:  state_d = (held_q == '0) ? ST_LOAD : ST_WAIT;
			ST_WAIT: begin
				if (div_done) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (!out_valid_q || result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sensor.ready = 1'b0;
		ram_we       = 1'b0;
		div_start    = 1'b0;
		load_out     = 1'b0;
		unique case (state_q)
			ST_IDLE:   sensor.ready = 1'b1;
			ST_UPDATE: ram_we = !word_fault;
			ST_START:  div_start = (held_q != '0);
			ST_LOAD:   load_out = !out_valid_q || result.ready;
			default: begin
				sensor.ready = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			oldest_q <= '0;
			held_q   <= '0;
			sum_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DROP) begin
				sum_q    <= sum_q - SUM_W'(ram_rdata);
				oldest_q <= oldest_next;
				held_q   <= WIN_DROP;
			end else if (state_q == ST_UPDATE && !word_fault) begin
				sum_q  <= sum_q + SUM_W'(word_temp);
				held_q <= held_q + 1'b1;
			end
		end
	end

	// accepted word and sign of the sum
	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			word_q <= sensor.raw_word;
		end
		if (div_start) begin
			neg_q <= (sum_q < 0);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_temp_q      <= word_temp;
			out_fault_q     <= word_fault;
			out_count_q     <= held_q;
			out_avg_valid_q <= (held_q != '0);
			out_avg_q       <= (held_q != '0) ? AVG_W'(avg_signed) : '0;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.temp_quarter      = out_temp_q;
	assign result.fault             = out_fault_q;
	assign result.window_count      = out_count_q;
	assign result.average_valid     = out_avg_valid_q;
	assign result.average_sixteenth = out_avg_q;

	// window never holds more than its depth
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= WIN_CNT)
		else $error("window count above depth");

	// no beat is taken while the divider is still working
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(sensor.valid && sensor.ready) |-> !div_busy)
		else $error("beat accepted during division");

	// divider finishes only while the sequencer waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_WAIT))
		else $error("divider done outside wait");

	// a full window is always reduced before the new reading is stored
	a_drop_before_store: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (held_q != WIN_CNT))
		else $error("store written with full window");

	// a presented result is consistent between count and average flag
	a_avg_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_avg_valid_q == (out_count_q != '0)))
		else $error("average flag disagrees with count");

endmodule
